>>> hw/rtl/ictm_pkg.sv
package ictm_pkg;

	localparam int CELL_W = 10;
	localparam int STEP_W = 31;
	localparam int COORD_W = 32;
	localparam int IDX_W = 32;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 32;
	localparam int SAMPLE_BITS_DEF = 24;
	localparam int FRAC_BITS_DEF = 16;
	localparam int MAX_RESOLUTION = 1024;
	localparam int NUM_TETS = 6;

	typedef logic [2:0] corner_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ISO_LEVEL = 3'd0,
		REG_ORIGIN_X  = 3'd1,
		REG_ORIGIN_Y  = 3'd2,
		REG_ORIGIN_Z  = 3'd3,
		REG_STEP_X    = 3'd4,
		REG_STEP_Y    = 3'd5,
		REG_STEP_Z    = 3'd6
	} cfg_reg_t;

	// Six tetrahedra around the diagonal from corner 0 to corner 6.
	localparam corner_t TET_TAB [NUM_TETS][4] = '{
		'{3'd0, 3'd1, 3'd2, 3'd6},
		'{3'd0, 3'd2, 3'd3, 3'd6},
		'{3'd0, 3'd3, 3'd7, 3'd6},
		'{3'd0, 3'd7, 3'd4, 3'd6},
		'{3'd0, 3'd4, 3'd5, 3'd6},
		'{3'd0, 3'd5, 3'd1, 3'd6}
	};

	// Corner offsets packed as {z, y, x}.
	localparam logic [2:0] CORNER_OFF [8] = '{
		3'b000, 3'b001, 3'b011, 3'b010, 3'b100, 3'b101, 3'b111, 3'b110
	};

endpackage

>>> hw/rtl/ictm_cube_if.sv
interface ictm_cube_if #(parameter int SAMPLE_BITS = 24);
	logic                          valid;
	logic                          ready;
	logic [9:0]                    cell_i;
	logic [9:0]                    cell_j;
	logic [9:0]                    cell_k;
	logic signed [SAMPLE_BITS-1:0] sample_0;
	logic signed [SAMPLE_BITS-1:0] sample_1;
	logic signed [SAMPLE_BITS-1:0] sample_2;
	logic signed [SAMPLE_BITS-1:0] sample_3;
	logic signed [SAMPLE_BITS-1:0] sample_4;
	logic signed [SAMPLE_BITS-1:0] sample_5;
	logic signed [SAMPLE_BITS-1:0] sample_6;
	logic signed [SAMPLE_BITS-1:0] sample_7;

	modport source (output valid, cell_i, cell_j, cell_k, sample_0, sample_1, sample_2,
		sample_3, sample_4, sample_5, sample_6, sample_7, input ready);
	modport sink (input valid, cell_i, cell_j, cell_k, sample_0, sample_1, sample_2,
		sample_3, sample_4, sample_5, sample_6, sample_7, output ready);
endinterface

>>> hw/rtl/ictm_rec_if.sv
interface ictm_rec_if;
	logic               valid;
	logic               ready;
	logic               rec_kind;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	logic signed [31:0] pos_z;
	logic [31:0]        vert_index;
	logic [31:0]        tri_second;
	logic [31:0]        tri_third;
	logic               last;

	modport source (output valid, rec_kind, pos_x, pos_y, pos_z, vert_index, tri_second,
		tri_third, last, input ready);
	modport sink (input valid, rec_kind, pos_x, pos_y, pos_z, vert_index, tri_second,
		tri_third, last, output ready);
endinterface

>>> hw/rtl/ictm_cfg_if.sv
interface ictm_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [31:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

>>> hw/rtl/isosurface_cube_tetra_mesher.sv
// Isosurface mesher for one grid cube, marching tetrahedra over six tetrahedra.
// The cube channel carries the cell indices and the eight corner samples; one
// beat is one cube. The record channel returns vertex records and triangle
// records, with last set on the final record of a cube. A cube that the surface
// does not cross gives no record. The cfg channel writes the
// iso level, origin and step registers; it is always ready.
// Each vertex starts the shared bit-serial divider in S_DST, waits in S_DWT
// while it forms the edge fraction and takes the quotient, then steps each
// axis through S_M1, S_M2 and S_M3 on the one shared multiplier. The record
// is handed over in S_M3 of the z axis. Triangle records are written in
// S_TOUT, and each tetrahedron is classified in S_TET.
// The block takes one cube at a time; cube ready is high only while it idles.
// Reset clears the sequencer, the vertex counter and the output valid flag, and
// sets the registers to iso level 0, origin 0 and step 1.0.
// If the receiver stalls, the record stays in the output register and the
// sequencer waits before it writes the next record.
module isosurface_cube_tetra_mesher #(
	parameter int SAMPLE_BITS = ictm_pkg::SAMPLE_BITS_DEF,
	parameter int FRAC_BITS = ictm_pkg::FRAC_BITS_DEF
) (
	input logic        clk,
	input logic        arst_n,
	ictm_cube_if.sink  cube,
	ictm_rec_if.source rec,
	ictm_cfg_if.sink   cfg
);
	import ictm_pkg::*;

	localparam int GW = CELL_W + 1 + FRAC_BITS;
	localparam int MB = (FRAC_BITS > CELL_W + 1) ? FRAC_BITS : CELL_W + 1;
	localparam int MW = STEP_W + MB;
	localparam int AW = MW + 1;
	localparam int SW = AW + 2;

	typedef enum logic [7:0] {
		S_IDLE = 8'b0000_0001,
		S_TET  = 8'b0000_0010,
		S_DST  = 8'b0000_0100,
		S_DWT  = 8'b0000_1000,
		S_M1   = 8'b0001_0000,
		S_M2   = 8'b0010_0000,
		S_M3   = 8'b0100_0000,
		S_TOUT = 8'b1000_0000
	} state_t;

	// Vertex hand-over happens at the end of the z axis in S_M3.
	state_t state_q;

	// Configuration registers.
	logic signed [SAMPLE_BITS-1:0] iso_q;
	logic signed [COORD_W-1:0]     origin_q [3];
	logic [STEP_W-1:0]             step_q [3];

	// Cube held during its work.
	logic [CELL_W-1:0]             cell_q [3];
	logic signed [SAMPLE_BITS-1:0] smp_q [8];
	logic [7:0]                    up_q;
	logic [2:0]                    tet_q;
	logic [2:0]                    last_tet_q;

	// Edge list of the current tetrahedron.
	corner_t    ea_q [4];
	corner_t    eb_q [4];
	logic       quad_q;
	logic [1:0] ecnt_q;
	logic       tcnt_q;
	logic [IDX_W-1:0] vix_q [4];
	logic [IDX_W-1:0] vctr_q;

	// Coordinate datapath.
	logic [1:0]                axis_q;
	logic [FRAC_BITS:0]        f_q;
	logic [MW-1:0]             mp_q;
	logic [AW-1:0]             acc_q;
	logic signed [COORD_W-1:0] pos_q [3];

	// Output register.
	logic               out_v_q;
	logic               kind_q;
	logic signed [31:0] px_q, py_q, pz_q;
	logic [31:0]        ia_q, ib_q, ic_q;
	logic               last_q;

	logic                          accept;
	logic                          out_free;
	logic                          out_load;
	logic signed [SAMPLE_BITS-1:0] smp_in [8];
	logic [CELL_W-1:0]             cell_in [3];
	logic [7:0]                    up_d;
	logic [NUM_TETS-1:0]           cross_d;
	logic [2:0]                    last_tet_d;

	logic [3:0]  u;
	logic [2:0]  ucnt;
	corner_t     ea_d [4];
	corner_t     eb_d [4];

	corner_t                       ca, cb;
	logic signed [SAMPLE_BITS:0]   num_s, den_s;
	logic [SAMPLE_BITS:0]          un, ud;
	logic                          div_busy;
	logic [FRAC_BITS:0]            div_quo;

	logic              oa, ob;
	logic [GW-1:0]     g;
	logic [MB-1:0]     mul_b;
	logic [STEP_W-1:0] step_sel;
	logic signed [SW-1:0] sum;
	logic signed [COORD_W-1:0] sat;

	assign accept   = cube.valid && cube.ready;
	assign out_free = !out_v_q || rec.ready;
	// A new record enters the output register at the end of a vertex or on a
	// triangle, whenever the register is free.
	assign out_load = out_free && (((state_q == S_M3) && (axis_q == 2'd2)) ||
		(state_q == S_TOUT));

	assign cube.ready = (state_q == S_IDLE);
	assign cfg.ready  = 1'b1;

	assign smp_in[0] = cube.sample_0;
	assign smp_in[1] = cube.sample_1;
	assign smp_in[2] = cube.sample_2;
	assign smp_in[3] = cube.sample_3;
	assign smp_in[4] = cube.sample_4;
	assign smp_in[5] = cube.sample_5;
	assign smp_in[6] = cube.sample_6;
	assign smp_in[7] = cube.sample_7;

	// Cell indices beyond the grid are clamped to its last cube.
	always_comb begin
		cell_in[0] = cube.cell_i;
		cell_in[1] = cube.cell_j;
		cell_in[2] = cube.cell_k;
		for (int a = 0; a < 3; a++) begin
			if (int'(cell_in[a]) >= MAX_RESOLUTION) begin
				cell_in[a] = CELL_W'(MAX_RESOLUTION - 1);
			end
		end
	end

	// Corner classes and the last tetrahedron that the surface crosses.
	always_comb begin
		logic [3:0] tu;
		for (int c = 0; c < 8; c++) begin
			up_d[c] = smp_in[c] >= iso_q;
		end
		last_tet_d = '0;
		for (int t = 0; t < NUM_TETS; t++) begin
			for (int i = 0; i < 4; i++) begin
				tu[i] = up_d[TET_TAB[t][i]];
			end
			cross_d[t] = (tu != 4'b0000) && (tu != 4'b1111);
			if (cross_d[t]) begin
				last_tet_d = 3'(t);
			end
		end
	end

	// Edge list of the current tetrahedron. With a lone corner, its edges to
	// the other corners fan out from it; with two above, the quad edges pair each
	// upper corner with each lower one.
	always_comb begin
		logic       want;
		logic       found;
		logic [1:0] odd;
		logic [1:0] s;
		logic [1:0] na, nb;
		corner_t    al [2];
		corner_t    bl [2];
		ucnt = '0;
		for (int i = 0; i < 4; i++) begin
			u[i] = up_q[TET_TAB[tet_q][i]];
			ucnt = ucnt + 3'(u[i]);
		end
		want  = (ucnt == 3'd1);
		found = 1'b0;
		odd   = '0;
		for (int i = 0; i < 4; i++) begin
			if (!found && (u[i] == want)) begin
				odd   = 2'(i);
				found = 1'b1;
			end
		end
		for (int i = 0; i < 4; i++) begin
			ea_d[i] = '0;
			eb_d[i] = '0;
		end
		s = '0;
		na = '0;
		nb = '0;
		al[0] = '0;
		al[1] = '0;
		bl[0] = '0;
		bl[1] = '0;
		if (ucnt != 3'd2) begin
			for (int i = 0; i < 4; i++) begin
				if (2'(i) != odd) begin
					ea_d[s] = TET_TAB[tet_q][odd];
					eb_d[s] = TET_TAB[tet_q][i];
					s = s + 1'b1;
				end
			end
		end else begin
			for (int i = 0; i < 4; i++) begin
				if (u[i]) begin
					al[na[0]] = TET_TAB[tet_q][i];
					na = na + 1'b1;
				end else begin
					bl[nb[0]] = TET_TAB[tet_q][i];
					nb = nb + 1'b1;
				end
			end
			ea_d[0] = al[0];
			eb_d[0] = bl[0];
			ea_d[1] = al[0];
			eb_d[1] = bl[1];
			ea_d[2] = al[1];
			eb_d[2] = bl[0];
			ea_d[3] = al[1];
			eb_d[3] = bl[1];
		end
	end

	// Divider operands: magnitudes of (iso - va) and (vb - va).
	assign ca    = ea_q[ecnt_q];
	assign cb    = eb_q[ecnt_q];
	assign num_s = {iso_q[SAMPLE_BITS-1], iso_q} - {smp_q[ca][SAMPLE_BITS-1], smp_q[ca]};
	assign den_s = {smp_q[cb][SAMPLE_BITS-1], smp_q[cb]} -
		{smp_q[ca][SAMPLE_BITS-1], smp_q[ca]};
	assign un    = num_s[SAMPLE_BITS] ? $unsigned(-num_s) : $unsigned(num_s);
	assign ud    = den_s[SAMPLE_BITS] ? $unsigned(-den_s) : $unsigned(den_s);

	ictm_div #(
		.SAMPLE_BITS (SAMPLE_BITS),
		.FRAC_BITS   (FRAC_BITS)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (state_q == S_DST),
		.num    (un),
		.den    (ud),
		.busy   (div_busy),
		.quo    (div_quo)
	);

	// Grid coordinate on the current axis: corner a plus the fraction toward b.
	always_comb begin
		logic [GW-1:0] base;
		oa   = CORNER_OFF[ca][axis_q];
		ob   = CORNER_OFF[cb][axis_q];
		base = (GW'(cell_q[axis_q]) + GW'(oa)) << FRAC_BITS;
		if (ob && !oa) begin
			g = base + GW'(f_q);
		end else if (oa && !ob) begin
			g = base - GW'(f_q);
		end else begin
			g = base;
		end
	end

	// One multiplier serves the fractional and the integer part in turn.
	assign step_sel = step_q[axis_q];
	assign mul_b    = (state_q == S_M1) ? MB'(g[FRAC_BITS-1:0]) : MB'(g[GW-1:FRAC_BITS]);
	assign sum      = SW'(origin_q[axis_q]) + $signed({2'b00, acc_q}) +
		$signed({3'b000, mp_q});

	// The world coordinate saturates to the signed 32-bit range.
	always_comb begin
		if (sum[SW-1:COORD_W-1] == '0 || sum[SW-1:COORD_W-1] == '1) begin
			sat = sum[COORD_W-1:0];
		end else if (sum[SW-1]) begin
			sat = {1'b1, {(COORD_W-1){1'b0}}};
		end else begin
			sat = {1'b0, {(COORD_W-1){1'b1}}};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iso_q <= '0;
			for (int a = 0; a < 3; a++) begin
				origin_q[a] <= '0;
				step_q[a]   <= STEP_W'(32'h0001_0000);
			end
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				REG_ISO_LEVEL: iso_q       <= cfg.data[SAMPLE_BITS-1:0];
				REG_ORIGIN_X:  origin_q[0] <= cfg.data;
				REG_ORIGIN_Y:  origin_q[1] <= cfg.data;
				REG_ORIGIN_Z:  origin_q[2] <= cfg.data;
				REG_STEP_X:    step_q[0]   <= cfg.data[STEP_W-1:0];
				REG_STEP_Y:    step_q[1]   <= cfg.data[STEP_W-1:0];
				REG_STEP_Z:    step_q[2]   <= cfg.data[STEP_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_v_q <= 1'b0;
			vctr_q  <= '0;
			tet_q   <= '0;
			ecnt_q  <= '0;
			tcnt_q  <= 1'b0;
			axis_q  <= '0;
		end else begin
			if (out_load) begin
				out_v_q <= 1'b1;
			end else if (rec.ready) begin
				out_v_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept && (cross_d != '0)) begin
						tet_q   <= '0;
						state_q <= S_TET;
					end
				end
				S_TET: begin
					if (u == 4'b0000 || u == 4'b1111) begin
						tet_q <= tet_q + 1'b1;
					end else begin
						ecnt_q  <= '0;
						tcnt_q  <= 1'b0;
						state_q <= S_DST;
					end
				end
				S_DST: state_q <= S_DWT;
				S_DWT: begin
					if (!div_busy) begin
						axis_q  <= '0;
						state_q <= S_M1;
					end
				end
				S_M1: state_q <= S_M2;
				S_M2: state_q <= S_M3;
				S_M3: begin
					if (axis_q != 2'd2) begin
						axis_q  <= axis_q + 1'b1;
						state_q <= S_M1;
					end else if (out_free) begin
						vctr_q  <= vctr_q + 1'b1;
						if (ecnt_q == (quad_q ? 2'd3 : 2'd2)) begin
							state_q <= S_TOUT;
						end else begin
							ecnt_q  <= ecnt_q + 1'b1;
							state_q <= S_DST;
						end
					end
				end
				S_TOUT: begin
					if (out_free) begin
						if (!quad_q || tcnt_q) begin
							if (tet_q == last_tet_q) begin
								state_q <= S_IDLE;
							end else begin
								tet_q   <= tet_q + 1'b1;
								state_q <= S_TET;
							end
						end else begin
							tcnt_q <= 1'b1;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cell_q     <= cell_in;
			smp_q      <= smp_in;
			up_q       <= up_d;
			last_tet_q <= last_tet_d;
		end
		if (state_q == S_TET) begin
			ea_q   <= ea_d;
			eb_q   <= eb_d;
			quad_q <= (ucnt == 3'd2);
		end
		if (state_q == S_DWT) begin
			f_q <= div_quo;
		end
		if (state_q == S_M1) begin
			mp_q <= MW'(step_sel) * MW'(mul_b);
		end
		if (state_q == S_M2) begin
			acc_q <= AW'((AW'(mp_q) + (AW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS);
			mp_q  <= MW'(step_sel) * MW'(mul_b);
		end
		if (state_q == S_M3 && axis_q != 2'd2) begin
			pos_q[axis_q] <= sat;
		end
		if (state_q == S_M3 && axis_q == 2'd2 && out_free) begin
			vix_q[ecnt_q] <= vctr_q;
			kind_q <= 1'b0;
			px_q   <= pos_q[0];
			py_q   <= pos_q[1];
			pz_q   <= sat;
			ia_q   <= vctr_q;
			ib_q   <= '0;
			ic_q   <= '0;
			last_q <= 1'b0;
		end
		if (state_q == S_TOUT && out_free) begin
			kind_q <= 1'b1;
			px_q   <= '0;
			py_q   <= '0;
			pz_q   <= '0;
			if (quad_q && tcnt_q) begin
				ia_q <= vix_q[1];
				ib_q <= vix_q[3];
				ic_q <= vix_q[2];
			end else begin
				ia_q <= vix_q[0];
				ib_q <= vix_q[1];
				ic_q <= vix_q[2];
			end
			last_q <= (!quad_q || tcnt_q) && (tet_q == last_tet_q);
		end
	end

	assign rec.valid      = out_v_q;
	assign rec.rec_kind   = kind_q;
	assign rec.pos_x      = px_q;
	assign rec.pos_y      = py_q;
	assign rec.pos_z      = pz_q;
	assign rec.vert_index = ia_q;
	assign rec.tri_second = ib_q;
	assign rec.tri_third  = ic_q;
	assign rec.last       = last_q;

endmodule

>>> hw/rtl/ictm_div.sv
module ictm_div #(
	parameter int SAMPLE_BITS = 24,
	parameter int FRAC_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [SAMPLE_BITS:0] num,
	input  logic [SAMPLE_BITS:0] den,
	output logic                 busy,
	output logic [FRAC_BITS:0]   quo
);
	localparam int NW = SAMPLE_BITS + FRAC_BITS + 2;
	localparam int CW = $clog2(FRAC_BITS + 2);

	logic [SAMPLE_BITS:0]   num_c;
	logic [NW-1:0]          dividend;
	logic [SAMPLE_BITS:0]   rem_q;
	logic [FRAC_BITS:0]     n_q;
	logic [FRAC_BITS:0]     q_q;
	logic [SAMPLE_BITS:0]   den_q;
	logic                   zero_q;
	logic                   busy_q;
	logic [CW-1:0]          cnt_q;
	logic [SAMPLE_BITS+1:0] trial;
	logic [SAMPLE_BITS+1:0] diff;
	logic                   ge;

	// Rounded quotient (num << F + den/2) / den, one bit per cycle.
	assign num_c    = (num > den) ? den : num;
	assign dividend = NW'({num_c, {FRAC_BITS{1'b0}}}) + NW'(den >> 1);
	assign trial    = {rem_q, n_q[FRAC_BITS]};
	assign ge       = trial >= {1'b0, den_q};
	assign diff     = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CW'(FRAC_BITS + 1);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= dividend[NW-1:FRAC_BITS+1];
			n_q    <= dividend[FRAC_BITS:0];
			den_q  <= den;
			zero_q <= (den == '0);
			q_q    <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[SAMPLE_BITS:0] : trial[SAMPLE_BITS:0];
			n_q   <= n_q << 1;
			q_q   <= {q_q[FRAC_BITS-1:0], ge};
		end
	end

	always_comb begin
		if (zero_q) begin
			quo = '0;
		end else if (q_q > (FRAC_BITS+1)'(1) << FRAC_BITS) begin
			quo = (FRAC_BITS+1)'(1) << FRAC_BITS;
		end else begin
			quo = q_q;
		end
	end

	assign busy = busy_q;

endmodule
